// ----- rtl/assert_macros.svh -----
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge while out of reset.
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that cons holds in the same cycle whenever ante holds.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  `ASSERT_PROP(label, clk, rst_n, (ante) |-> (cons), msg)

`endif

// ----- rtl/vcs_pkg.sv -----
package vcs_pkg;

  localparam int FieldW      = 16;
  localparam int SpeedW      = 16;
  localparam int KnotsW      = 17;
  localparam int KphW        = 18;

  // Pipeline layout: front end, one square-root step per stage, rounding.
  localparam int FrontStages = 3;
  localparam int RootSteps   = 31;
  localparam int RootW       = 2 * RootSteps;
  localparam int RoundStages = 4;
  localparam int RootStage0  = FrontStages;
  localparam int RoundStage0 = FrontStages + RootSteps;
  localparam int NumStages   = RoundStage0 + RoundStages;

  typedef logic [NumStages-1:0] stage_vec_t;

  localparam int SumW = 32;

  // Radicand scale factors: 4 * 18^2 and 4 * 12149^2.
  localparam logic [10:0] KphRadMul  = 11'd1296;
  localparam logic [29:0] KnotRadMul = 30'd590392804;

  // Rounded division of the root by 2*d, done as a reciprocal multiply.
  localparam int CmpsRootW = 17;
  localparam int KphNW     = 21;
  localparam logic [2:0]  KphBias   = 3'd5;
  localparam logic [3:0]  KphDiv    = 4'd10;
  localparam logic [18:0] KphRecip  = 19'd419430;
  localparam int KphShift  = 22;
  localparam int KphPW     = KphNW + 19;
  localparam int KphQW     = KphPW - KphShift;
  localparam int KphMW     = KphQW + 4;

  localparam logic [12:0] KnotBias  = 13'd6250;
  localparam logic [13:0] KnotDiv   = 14'd12500;
  localparam logic [17:0] KnotRecip = 18'd171798;
  localparam int KnotShift = 31;
  localparam int KnotPW    = RootSteps + 18;
  localparam int KnotQW    = KnotPW - KnotShift;
  localparam int KnotMW    = KnotQW + 14;

  // CORDIC course path. Angle unit is 1/1024 of a hundredth of a degree.
  localparam int CordicIters   = 20;
  localparam int CordicW       = 44;
  localparam int AngleW        = 26;
  localparam int ScaleShift    = 24;
  localparam int AngleFracBits = 10;
  localparam logic signed [AngleW-1:0] QuarterTurn = 26'sd9216000;
  localparam logic signed [AngleW-1:0] AngleRound  = 26'sd512;
  localparam logic signed [FieldW-1:0] CourseMax     = 16'sd18000;
  localparam logic signed [FieldW-1:0] CourseQuarter = 16'sd9000;
  localparam int CourseStage = CordicIters + 2;
  localparam int CourseDelay = NumStages - CourseStage;

  function automatic logic signed [AngleW-1:0] atan_lut(input logic [4:0] idx);
    logic signed [AngleW-1:0] val;
    case (idx)
      5'd0:    val = 26'sd4608000;
      5'd1:    val = 26'sd2720261;
      5'd2:    val = 26'sd1437311;
      5'd3:    val = 26'sd729602;
      5'd4:    val = 26'sd366217;
      5'd5:    val = 26'sd183287;
      5'd6:    val = 26'sd91666;
      5'd7:    val = 26'sd45836;
      5'd8:    val = 26'sd22918;
      5'd9:    val = 26'sd11459;
      5'd10:   val = 26'sd5730;
      5'd11:   val = 26'sd2865;
      5'd12:   val = 26'sd1432;
      5'd13:   val = 26'sd716;
      5'd14:   val = 26'sd358;
      5'd15:   val = 26'sd179;
      5'd16:   val = 26'sd90;
      5'd17:   val = 26'sd45;
      5'd18:   val = 26'sd22;
      5'd19:   val = 26'sd11;
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

// ----- rtl/vcs_sqsum.sv -----
module vcs_sqsum import vcs_pkg::*; (
  input  logic                     clk_i,
  input  logic [FrontStages-1:0]   stage_en_i,
  input  logic signed [FieldW-1:0] vel_x_i,
  input  logic signed [FieldW-1:0] vel_y_i,
  input  logic signed [FieldW-1:0] vel_z_i,
  output logic [RootW-1:0]         rad_cmps_o,
  output logic [RootW-1:0]         rad_kph_o,
  output logic [RootW-1:0]         rad_knots_o
);

  logic signed [2*FieldW-1:0] prod_x, prod_y, prod_z;
  logic [2*FieldW-2:0]        sq_x_q, sq_y_q, sq_z_q;
  logic [SumW-1:0]            sum_q;
  logic [RootW-1:0]           rad_cmps_q, rad_kph_q, rad_knots_q;

  always_comb begin
    prod_x = vel_x_i * vel_x_i;
    prod_y = vel_y_i * vel_y_i;
    prod_z = vel_z_i * vel_z_i;
  end

  // squares are never negative and never above 2^30
  always_ff @(posedge clk_i) begin
    if (stage_en_i[0]) begin
      sq_x_q <= prod_x[2*FieldW-2:0];
      sq_y_q <= prod_y[2*FieldW-2:0];
      sq_z_q <= prod_z[2*FieldW-2:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_en_i[1]) begin
      sum_q <= SumW'(sq_x_q) + SumW'(sq_y_q) + SumW'(sq_z_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_en_i[2]) begin
      rad_cmps_q  <= RootW'({sum_q, 2'b00});
      rad_kph_q   <= RootW'(sum_q) * RootW'(KphRadMul);
      rad_knots_q <= RootW'(sum_q) * RootW'(KnotRadMul);
    end
  end

  assign rad_cmps_o  = rad_cmps_q;
  assign rad_kph_o   = rad_kph_q;
  assign rad_knots_o = rad_knots_q;

endmodule

// ----- rtl/vcs_isqrt.sv -----
module vcs_isqrt import vcs_pkg::*; (
  input  logic                 clk_i,
  input  logic [RootSteps-1:0] step_en_i,
  input  logic [RootW-1:0]     rad_i,
  output logic [RootSteps-1:0] root_o
);

  logic [RootW-1:0] rem_q [RootSteps-1];
  logic [RootW-1:0] res_q [RootSteps];

  // One result bit per stage, trial bit walking down by powers of four.
  for (genvar k = 0; k < RootSteps; k++) begin : g_step
    localparam logic [RootW-1:0] TrialBit = RootW'(1) << (RootW - 2 - 2 * k);

    logic [RootW-1:0] rem_in, res_in, res_d;
    logic [RootW:0]   trial;
    logic             fits;

    if (k == 0) begin : g_first
      assign rem_in = rad_i;
      assign res_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign res_in = res_q[k-1];
    end

    always_comb begin
      trial = {1'b0, res_in} + {1'b0, TrialBit};
      fits  = {1'b0, rem_in} >= trial;
      res_d = fits ? (res_in >> 1) + TrialBit : res_in >> 1;
    end

    always_ff @(posedge clk_i) begin
      if (step_en_i[k]) begin
        res_q[k] <= res_d;
      end
    end

    // the remainder is dead after the last step
    if (k < RootSteps - 1) begin : g_rem
      logic [RootW-1:0] rem_d;

      always_comb begin
        rem_d = fits ? rem_in - trial[RootW-1:0] : rem_in;
      end

      always_ff @(posedge clk_i) begin
        if (step_en_i[k]) begin
          rem_q[k] <= rem_d;
        end
      end
    end
  end

  assign root_o = res_q[RootSteps-1][RootSteps-1:0];

endmodule

// ----- rtl/vcs_round.sv -----
module vcs_round import vcs_pkg::*; (
  input  logic                   clk_i,
  input  logic [RoundStages-1:0] stage_en_i,
  input  logic [RootSteps-1:0]   root_cmps_i,
  input  logic [RootSteps-1:0]   root_kph_i,
  input  logic [RootSteps-1:0]   root_knots_i,
  output logic [SpeedW-1:0]      speed_cmps_o,
  output logic [KnotsW-1:0]      speed_centiknots_o,
  output logic [KphW-1:0]        speed_centikph_o
);

  logic [CmpsRootW:0]  cm_sum;
  logic [SpeedW-1:0]   cm1_q, cm2_q, cm3_q, cm4_q;

  logic [KphNW-1:0]    kp_n1_q, kp_n2_q, kp_n3_q;
  logic [KphPW-1:0]    kp_p2_q;
  logic [KphQW-1:0]    kp_q0, kp_q3_q;
  logic [KphMW-1:0]    kp_m3_q, kp_rem;
  logic [KphW-1:0]     kp4_q;

  logic [RootSteps-1:0] kn_n1_q, kn_n2_q, kn_n3_q;
  logic [KnotPW-1:0]    kn_p2_q;
  logic [KnotQW-1:0]    kn_q0, kn_q3_q;
  logic [KnotMW-1:0]    kn_m3_q, kn_rem;
  logic [KnotsW-1:0]    kn4_q;

  always_comb begin
    cm_sum = {1'b0, root_cmps_i[CmpsRootW-1:0]} + (CmpsRootW + 1)'(1);
    kp_q0  = kp_p2_q[KphPW-1:KphShift];
    kn_q0  = kn_p2_q[KnotPW-1:KnotShift];
    kp_rem = KphMW'(kp_n3_q) - kp_m3_q;
    kn_rem = KnotMW'(kn_n3_q) - kn_m3_q;
  end

  // add the rounding bias
  always_ff @(posedge clk_i) begin
    if (stage_en_i[0]) begin
      cm1_q   <= cm_sum[SpeedW:1];
      kp_n1_q <= root_kph_i[KphNW-1:0] + KphNW'(KphBias);
      kn_n1_q <= root_knots_i + RootSteps'(KnotBias);
    end
  end

  // multiply by the reciprocal of the divisor
  always_ff @(posedge clk_i) begin
    if (stage_en_i[1]) begin
      cm2_q   <= cm1_q;
      kp_n2_q <= kp_n1_q;
      kn_n2_q <= kn_n1_q;
      kp_p2_q <= KphPW'(kp_n1_q) * KphPW'(KphRecip);
      kn_p2_q <= KnotPW'(kn_n1_q) * KnotPW'(KnotRecip);
    end
  end

  // estimate is exact or one short; form estimate times divisor
  always_ff @(posedge clk_i) begin
    if (stage_en_i[2]) begin
      cm3_q   <= cm2_q;
      kp_n3_q <= kp_n2_q;
      kn_n3_q <= kn_n2_q;
      kp_q3_q <= kp_q0;
      kn_q3_q <= kn_q0;
      kp_m3_q <= KphMW'(kp_q0) * KphMW'(KphDiv);
      kn_m3_q <= KnotMW'(kn_q0) * KnotMW'(KnotDiv);
    end
  end

  // bump the estimate when the remainder still holds a full divisor
  always_ff @(posedge clk_i) begin
    if (stage_en_i[3]) begin
      cm4_q <= cm3_q;
      kp4_q <= kp_q3_q[KphW-1:0] + KphW'(kp_rem >= KphMW'(KphDiv));
      kn4_q <= kn_q3_q[KnotsW-1:0] + KnotsW'(kn_rem >= KnotMW'(KnotDiv));
    end
  end

  assign speed_cmps_o       = cm4_q;
  assign speed_centikph_o   = kp4_q;
  assign speed_centiknots_o = kn4_q;

endmodule

// ----- rtl/vcs_cordic.sv -----
module vcs_cordic import vcs_pkg::*; (
  input  logic                     clk_i,
  input  stage_vec_t               stage_en_i,
  input  logic signed [FieldW-1:0] vel_x_i,
  input  logic signed [FieldW-1:0] vel_y_i,
  output logic signed [FieldW-1:0] course_o
);

  logic signed [FieldW-1:0]  x_q, y_q;
  logic signed [FieldW:0]    neg_y;
  logic signed [CordicW-1:0] xb0, ya0, cx_d, cy_d;
  logic signed [AngleW-1:0]  cz_d;
  logic                      x_zero, y_zero, sp_d;
  logic signed [FieldW-1:0]  spv_d;

  logic signed [CordicW-1:0] cx_q  [CordicIters];
  logic signed [CordicW-1:0] cy_q  [CordicIters];
  logic signed [AngleW-1:0]  cz_q  [CordicIters+1];
  logic                      sp_q  [CordicIters+1];
  logic signed [FieldW-1:0]  spv_q [CordicIters+1];

  logic signed [AngleW-1:0]  zr, ang;
  logic signed [FieldW-1:0]  crs_n, crs_d;
  logic signed [FieldW-1:0]  crs_q [CourseDelay];

  always_ff @(posedge clk_i) begin
    if (stage_en_i[0]) begin
      x_q <= vel_x_i;
      y_q <= vel_y_i;
    end
  end

  // Quarter-turn pre-rotation into the right half plane, axis cases exact.
  always_comb begin
    neg_y  = -$signed({y_q[FieldW-1], y_q});
    xb0    = CordicW'(x_q) <<< ScaleShift;
    ya0    = CordicW'(neg_y) <<< ScaleShift;
    x_zero = (x_q == '0);
    y_zero = (y_q == '0);
    if (x_q[FieldW-1]) begin
      if (!neg_y[FieldW]) begin
        cx_d = ya0;
        cy_d = -xb0;
        cz_d = QuarterTurn;
      end else begin
        cx_d = -ya0;
        cy_d = xb0;
        cz_d = -QuarterTurn;
      end
    end else begin
      cx_d = xb0;
      cy_d = ya0;
      cz_d = '0;
    end
    sp_d = x_zero | y_zero;
    if (y_zero) begin
      spv_d = x_q[FieldW-1] ? -CourseMax : '0;
    end else begin
      spv_d = y_q[FieldW-1] ? CourseQuarter : -CourseQuarter;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_en_i[1]) begin
      cx_q[0]  <= cx_d;
      cy_q[0]  <= cy_d;
      cz_q[0]  <= cz_d;
      sp_q[0]  <= sp_d;
      spv_q[0] <= spv_d;
    end
  end

  // One vectoring micro-rotation per stage.
  for (genvar i = 0; i < CordicIters; i++) begin : g_iter
    localparam logic signed [AngleW-1:0] Atan = atan_lut(5'(i));

    logic ccw;

    assign ccw = !cy_q[i][CordicW-1];

    always_ff @(posedge clk_i) begin
      if (stage_en_i[2+i]) begin
        cz_q[i+1]  <= ccw ? cz_q[i] + Atan : cz_q[i] - Atan;
        sp_q[i+1]  <= sp_q[i];
        spv_q[i+1] <= spv_q[i];
      end
    end

    if (i < CordicIters - 1) begin : g_xy
      logic signed [CordicW-1:0] xs, ys;

      always_comb begin
        xs = cx_q[i] >>> i;
        ys = cy_q[i] >>> i;
      end

      always_ff @(posedge clk_i) begin
        if (stage_en_i[2+i]) begin
          cx_q[i+1] <= ccw ? cx_q[i] + ys : cx_q[i] - ys;
          cy_q[i+1] <= ccw ? cy_q[i] - xs : cy_q[i] + xs;
        end
      end
    end
  end

  // Round to hundredths of a degree and clamp.
  always_comb begin
    zr    = cz_q[CordicIters] + AngleRound;
    ang   = zr >>> AngleFracBits;
    crs_n = FieldW'(ang);
    if (sp_q[CordicIters]) begin
      crs_d = spv_q[CordicIters];
    end else if (crs_n > CourseMax) begin
      crs_d = CourseMax;
    end else if (crs_n < -CourseMax) begin
      crs_d = -CourseMax;
    end else begin
      crs_d = crs_n;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_en_i[CourseStage]) begin
      crs_q[0] <= crs_d;
    end
  end

  // Hold the course alongside the longer speed path.
  for (genvar j = 1; j < CourseDelay; j++) begin : g_delay
    always_ff @(posedge clk_i) begin
      if (stage_en_i[CourseStage+j]) begin
        crs_q[j] <= crs_q[j-1];
      end
    end
  end

  assign course_o = crs_q[CourseDelay-1];

endmodule

// ----- rtl/velocity_to_course_and_speed.sv -----
// Velocity to course and speed.
// Input channel: in_valid_i/in_ready_o carry one request, a signed velocity
// vector vel_x_i, vel_y_i, vel_z_i in cm/s. Output channel:
// out_valid_o/out_ready_i carry one result per request: course_centideg_o
// (atan2(-y, x) in 0.01 degree), speed_cmps_o, speed_centiknots_o and
// speed_centikph_o (3-D magnitude, rounded to nearest).
// Throughput: one request per cycle while out_ready_i is high or a stage
// is empty; the depth is set by the 31-stage digit-by-digit square root,
// one root bit per stage, with three front stages (squares, sum, scale)
// and four rounding stages behind it. The 20-step CORDIC for the course
// runs beside it and is delayed to match.
// Reset: rst_ni clears every stage valid bit; the pipeline comes up empty
// and ready. Payload registers are not reset.
// Stall: a stage holds its request while the stage after it is full and
// not moving. Bubbles close up, so in_ready_o stays high as long as any
// stage is empty, even while a finished result waits at the output.
`include "assert_macros.svh"

module velocity_to_course_and_speed import vcs_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic signed [FieldW-1:0] vel_x_i,
  input  logic signed [FieldW-1:0] vel_y_i,
  input  logic signed [FieldW-1:0] vel_z_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [FieldW-1:0] course_centideg_o,
  output logic [SpeedW-1:0]        speed_cmps_o,
  output logic [KnotsW-1:0]        speed_centiknots_o,
  output logic [KphW-1:0]          speed_centikph_o
);

  stage_vec_t valid_q, valid_d, stage_en;

  logic [RootW-1:0]     rad_cmps, rad_kph, rad_knots;
  logic [RootSteps-1:0] root_cmps, root_kph, root_knots;
  logic                 in_fire, out_fire;

  // A stage may load when it or some stage downstream of it is empty, or
  // when the receiver takes the result this cycle.
  for (genvar k = 0; k < NumStages; k++) begin : g_en
    assign stage_en[k] = out_ready_i | ~&valid_q[NumStages-1:k];
  end

  // Advance valid bits together with the data they guard.
  always_comb begin
    valid_d[0] = stage_en[0] ? in_valid_i : valid_q[0];
    for (int k = 1; k < NumStages; k++) begin
      valid_d[k] = stage_en[k] ? valid_q[k-1] : valid_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign in_ready_o  = stage_en[0];
  assign out_valid_o = valid_q[NumStages-1];
  assign in_fire     = in_valid_i & in_ready_o;
  assign out_fire    = out_valid_o & out_ready_i;

  // Front end: squares, sum of squares, scaled radicands.
  vcs_sqsum u_sqsum (
    .clk_i       (clk_i),
    .stage_en_i  (stage_en[FrontStages-1:0]),
    .vel_x_i     (vel_x_i),
    .vel_y_i     (vel_y_i),
    .vel_z_i     (vel_z_i),
    .rad_cmps_o  (rad_cmps),
    .rad_kph_o   (rad_kph),
    .rad_knots_o (rad_knots)
  );

  // Three square roots in lockstep, one per output unit.
  vcs_isqrt u_isqrt_cmps (
    .clk_i     (clk_i),
    .step_en_i (stage_en[RoundStage0-1:RootStage0]),
    .rad_i     (rad_cmps),
    .root_o    (root_cmps)
  );

  vcs_isqrt u_isqrt_kph (
    .clk_i     (clk_i),
    .step_en_i (stage_en[RoundStage0-1:RootStage0]),
    .rad_i     (rad_kph),
    .root_o    (root_kph)
  );

  vcs_isqrt u_isqrt_knots (
    .clk_i     (clk_i),
    .step_en_i (stage_en[RoundStage0-1:RootStage0]),
    .rad_i     (rad_knots),
    .root_o    (root_knots)
  );

  // Rounded division of each root; the last stage is the output register.
  vcs_round u_round (
    .clk_i              (clk_i),
    .stage_en_i         (stage_en[NumStages-1:RoundStage0]),
    .root_cmps_i        (root_cmps),
    .root_kph_i         (root_kph),
    .root_knots_i       (root_knots),
    .speed_cmps_o       (speed_cmps_o),
    .speed_centiknots_o (speed_centiknots_o),
    .speed_centikph_o   (speed_centikph_o)
  );

  // Course path, aligned to the same output stage.
  vcs_cordic u_cordic (
    .clk_i      (clk_i),
    .stage_en_i (stage_en),
    .vel_x_i    (vel_x_i),
    .vel_y_i    (vel_y_i),
    .course_o   (course_centideg_o)
  );

  // A taken request must land in the first stage.
  `ASSERT_PROP(a_take_lands, clk_i, rst_ni, (in_fire && rst_ni) |=> valid_q[0], "request lost at entry")

  // Requests in flight change only by what enters and what leaves.
  `ASSERT_IMPL(a_occupancy, clk_i, rst_ni, $past(rst_ni), $countones(valid_q) == $countones($past(valid_q)) + $past(in_fire) - $past(out_fire), "pipeline occupancy broken")

  // Course stays within a half turn either way.
  `ASSERT_IMPL(a_course_range, clk_i, rst_ni, out_valid_o, (course_centideg_o <= CourseMax) && (course_centideg_o >= -CourseMax), "course out of range")

  // All three speed lanes agree on a standing vehicle.
  `ASSERT_IMPL(a_speed_zero, clk_i, rst_ni, out_valid_o, ((speed_cmps_o == '0) == (speed_centikph_o == '0)) && ((speed_centiknots_o == '0) == (speed_centikph_o == '0)), "speed lanes disagree on zero")

endmodule

// ----- bench/velocity_to_course_and_speed_test.sv -----
module velocity_to_course_and_speed_test;
  import vcs_pkg::*;

  // Course arithmetic: angles count 1/1024 of a hundredth of a degree,
  // vectors are scaled by 2^24 before the CORDIC runs.
  localparam int     CordicSteps  = 20;
  localparam int     VectorShift  = 24;
  localparam longint QuarterAngle = 64'sd9216000;
  localparam longint HalfStep     = 64'sd512;
  localparam int     StepFracBits = 10;
  localparam longint CourseLimit  = 64'sd18000;
  localparam longint CourseRight  = 64'sd9000;

  // Speed scale factors as exact ratios to cm/s: centiknots = 12149/6250, centi-km/h = 18/5.
  localparam logic [63:0] KnotNum = 64'd12149;
  localparam logic [63:0] KnotDen = 64'd6250;
  localparam logic [63:0] KphNum  = 64'd18;
  localparam logic [63:0] KphDen  = 64'd5;

  localparam int IdlePercent = 25;
  localparam int HoldCycles  = 160;
  localparam int TailCycles  = 48;

  // Drive every input to a known value from time zero; reset starts asserted.
  logic                     clk_i       = 1'b0;
  logic                     rst_ni      = 1'b0;
  logic                     in_valid_i  = 1'b0;
  logic                     in_ready_o;
  logic signed [FieldW-1:0] vel_x_i     = '0;
  logic signed [FieldW-1:0] vel_y_i     = '0;
  logic signed [FieldW-1:0] vel_z_i     = '0;
  logic                     out_valid_o;
  logic                     out_ready_i = 1'b0;
  logic signed [FieldW-1:0] course_centideg_o;
  logic [SpeedW-1:0]        speed_cmps_o;
  logic [KnotsW-1:0]        speed_centiknots_o;
  logic [KphW-1:0]          speed_centikph_o;

  typedef struct {
    logic signed [FieldW-1:0] course;
    logic [SpeedW-1:0]        cmps;
    logic [KnotsW-1:0]        knots;
    logic [KphW-1:0]          kph;
  } motion_t;

  // Expected course and speeds, one per accepted request, oldest first.
  motion_t motion_q[$];
  motion_t head;

  int error_count = 0;
  // Set by the test sequence only: no random idling on either side.
  bit steady = 1'b0;
  // Bump hold_asked to make the receiver hold off; it counts the stall itself.
  int hold_asked = 0;
  int hold_seen  = 0;
  int hold_left  = 0;

  velocity_to_course_and_speed uut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .vel_x_i            (vel_x_i),
    .vel_y_i            (vel_y_i),
    .vel_z_i            (vel_z_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .course_centideg_o  (course_centideg_o),
    .speed_cmps_o       (speed_cmps_o),
    .speed_centiknots_o (speed_centiknots_o),
    .speed_centikph_o   (speed_centikph_o)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // Rounded atan(2^-i) in angle units.
  function automatic longint arc_step(input int i);
    longint val;
    case (i)
      0:  val = 4608000;
      1:  val = 2720261;
      2:  val = 1437311;
      3:  val = 729602;
      4:  val = 366217;
      5:  val = 183287;
      6:  val = 91666;
      7:  val = 45836;
      8:  val = 22918;
      9:  val = 11459;
      10: val = 5730;
      11: val = 2865;
      12: val = 1432;
      13: val = 716;
      14: val = 358;
      15: val = 179;
      16: val = 90;
      17: val = 45;
      18: val = 22;
      19: val = 11;
      default: val = 0;
    endcase
    return val;
  endfunction

  // Course in hundredths of a degree for atan2(-y, x).
  function automatic logic signed [FieldW-1:0] course_of(input int x, input int y);
    longint px;
    longint py;
    longint ang;
    longint t;
    longint dx;
    longint dy;
    longint n;
    int     i;
    if (x == 0 && y == 0) begin
      n = 0;
    end else if (y == 0) begin
      // Negative x axis lands on -180 degrees, not +180.
      n = (x > 0) ? 64'sd0 : -CourseLimit;
    end else if (x == 0) begin
      n = (y < 0) ? CourseRight : -CourseRight;
    end else begin
      px  = longint'(x) * (64'sd1 <<< VectorShift);
      py  = -longint'(y) * (64'sd1 <<< VectorShift);
      ang = 0;
      // Pre-rotate the left half plane by a quarter turn.
      if (px < 0) begin
        t = px;
        if (py >= 0) begin
          px  = py;
          py  = -t;
          ang = QuarterAngle;
        end else begin
          px  = -py;
          py  = t;
          ang = -QuarterAngle;
        end
      end
      for (i = 0; i < CordicSteps; i++) begin
        // Arithmetic shift of a signed value floors, as the block does.
        dx = px >>> i;
        dy = py >>> i;
        if (py >= 0) begin
          px  = px + dy;
          py  = py - dx;
          ang = ang + arc_step(i);
        end else begin
          px  = px - dy;
          py  = py + dx;
          ang = ang - arc_step(i);
        end
      end
      n = (ang + HalfStep) >>> StepFracBits;
      if (n > CourseLimit) n = CourseLimit;
      if (n < -CourseLimit) n = -CourseLimit;
    end
    return n[FieldW-1:0];
  endfunction

  // Floor of the square root, one result bit per pass.
  function automatic logic [63:0] root_floor(input logic [63:0] v);
    logic [63:0] res;
    logic [63:0] probe;
    res   = '0;
    probe = 64'd1 << 62;
    while (probe > v) probe = probe >> 2;
    while (probe != 0) begin
      if (v >= res + probe) begin
        v   = v - (res + probe);
        res = (res >> 1) + probe;
      end else begin
        res = res >> 1;
      end
      probe = probe >> 2;
    end
    return res;
  endfunction

  // round(sqrt(s) * num / den), ties up, with no fractional arithmetic.
  function automatic logic [63:0] scaled_speed(input logic [63:0] s, input logic [63:0] num,
                                               input logic [63:0] den);
    logic [63:0] r;
    r = root_floor(64'd4 * s * num * num);
    return (r + den) / (64'd2 * den);
  endfunction

  function automatic motion_t predict_motion(input logic signed [FieldW-1:0] x,
                                             input logic signed [FieldW-1:0] y,
                                             input logic signed [FieldW-1:0] z);
    motion_t     m;
    longint      sq;
    logic [63:0] sum;
    logic [63:0] v;
    sq  = longint'(x) * longint'(x) + longint'(y) * longint'(y) + longint'(z) * longint'(z);
    sum = sq;
    m.course = course_of(int'(x), int'(y));
    v        = scaled_speed(sum, 64'd1, 64'd1);
    m.cmps   = v[SpeedW-1:0];
    v        = scaled_speed(sum, KnotNum, KnotDen);
    m.knots  = v[KnotsW-1:0];
    v        = scaled_speed(sum, KphNum, KphDen);
    m.kph    = v[KphW-1:0];
    return m;
  endfunction

  // Mix full-range values with small ones, zeros and values near the extremes.
  function automatic logic signed [FieldW-1:0] pick_component();
    int unsigned kind;
    int          v;
    kind = $urandom_range(99);
    if (kind < 55) begin
      v = $urandom;
    end else if (kind < 70) begin
      v = int'($urandom_range(64)) - 32;
    end else if (kind < 80) begin
      v = 0;
    end else if (kind < 90) begin
      v = ($urandom_range(1) != 0) ? 32767 : -32768;
    end else begin
      v = int'($urandom_range(255)) - 32768 + (($urandom_range(1) != 0) ? 65280 : 0);
    end
    return v[FieldW-1:0];
  endfunction

  // Offer one request, wait for it to be taken and queue its expected result.
  // Valid stays high after acceptance; the next call replaces the payload or
  // drops valid for a gap in the same step.
  task automatic send_vector(input logic signed [FieldW-1:0] x,
                             input logic signed [FieldW-1:0] y,
                             input logic signed [FieldW-1:0] z);
    while (!steady && $urandom_range(99) < IdlePercent) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    vel_x_i    <= x;
    vel_y_i    <= y;
    vel_z_i    <= z;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    motion_q.push_back(predict_motion(x, y, z));
  endtask

  // Drop valid and hold until every pending result has come back.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (motion_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic send_random(input int count);
    int k;
    for (k = 0; k < count; k++) send_vector(pick_component(), pick_component(),
                                            pick_component());
  endtask

  // Zero vector, the four axis directions and two diagonals.
  task automatic test_special_directions();
    send_vector(16'sd0, 16'sd0, 16'sd0);
    send_vector(16'sd0, 16'sd0, 16'sd77);
    send_vector(16'sd1000, 16'sd0, 16'sd0);
    send_vector(16'sd1, 16'sd0, 16'sd0);
    send_vector(-16'sd1000, 16'sd0, 16'sd0);
    send_vector(-16'sd1, 16'sd0, 16'sd5);
    send_vector(16'sd0, 16'sd500, 16'sd0);
    send_vector(16'sd0, -16'sd500, 16'sd0);
    send_vector(16'sd0, -16'sd1, -16'sd3);
    send_vector(16'sd300, 16'sd300, 16'sd0);
    send_vector(-16'sd300, -16'sd300, 16'sd0);
  endtask

  // Field extremes, including the largest possible speed.
  task automatic test_field_extremes();
    send_vector(-16'sd32768, -16'sd32768, -16'sd32768);
    send_vector(16'sd32767, 16'sd32767, 16'sd32767);
    send_vector(-16'sd32768, 16'sd32767, 16'sd0);
    send_vector(16'sd32767, -16'sd32768, -16'sd32768);
    send_vector(16'sd0, 16'sd0, -16'sd32768);
    send_vector(16'sd0, 16'sd0, 16'sd32767);
    send_vector(-16'sd32768, 16'sd0, 16'sd0);
    send_vector(16'sd0, -16'sd32768, 16'sd0);
    send_vector(16'sd32767, 16'sd0, 16'sd0);
    send_vector(-16'sd1, -16'sd1, -16'sd1);
    send_vector(16'sd1, -16'sd1, 16'sd0);
    send_vector(-16'sd1, 16'sd1, 16'sd0);
  endtask

  task automatic test_random_traffic();
    send_random(830);
  endtask

  // No idling on either side: back-to-back requests and results.
  task automatic test_steady_stream();
    steady = 1'b1;
    send_random(250);
    steady = 1'b0;
  endtask

  // Hold the output off long enough for the pipeline to fill and stall input.
  task automatic test_output_hold();
    steady = 1'b1;
    hold_asked++;
    send_random(150);
    steady = 1'b0;
  endtask

  // Pause the sender until the block has emptied, then resume.
  task automatic test_sender_pause();
    send_random(100);
    wait_drained();
    send_random(100);
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_special_directions();
    test_field_extremes();
    test_random_traffic();
    test_steady_stream();
    test_output_hold();
    test_sender_pause();
    wait_drained();
    // Let any stray extra result show up before judging.
    repeat (TailCycles) @(posedge clk_i);
    if (error_count == 0) begin
      $display("[velocity_to_course_and_speed] OK");
    end else begin
      $display("[velocity_to_course_and_speed] ERROR");
    end
    $finish;
  end

  // Result side: check each accepted result, then pick the next ready value.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (motion_q.size() == 0) begin
          $error("unexpected result: course_centideg %0d, speed_cmps %0d",
                 course_centideg_o, speed_cmps_o);
          error_count++;
        end else begin
          head = motion_q.pop_front();
          if (course_centideg_o !== head.course) begin
            $error("course_centideg: expected %0d, got %0d", head.course, course_centideg_o);
            error_count++;
          end
          if (speed_cmps_o !== head.cmps) begin
            $error("speed_cmps: expected %0d, got %0d", head.cmps, speed_cmps_o);
            error_count++;
          end
          if (speed_centiknots_o !== head.knots) begin
            $error("speed_centiknots: expected %0d, got %0d", head.knots, speed_centiknots_o);
            error_count++;
          end
          if (speed_centikph_o !== head.kph) begin
            $error("speed_centikph: expected %0d, got %0d", head.kph, speed_centikph_o);
            error_count++;
          end
        end
      end
      if (hold_asked != hold_seen) begin
        hold_seen = hold_asked;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= steady || ($urandom_range(99) >= IdlePercent);
      end
    end
  end

  // Guard against a hung handshake.
  initial begin
    #2000000;
    $display("[velocity_to_course_and_speed] ERROR");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/vcs_pkg.sv
rtl/vcs_sqsum.sv
rtl/vcs_isqrt.sv
rtl/vcs_round.sv
rtl/vcs_cordic.sv
rtl/velocity_to_course_and_speed.sv
bench/velocity_to_course_and_speed_test.sv
